>>> sv/quaternion_to_euler_angles_unit_defines.svh
// assertion macros used by the checker file
// no dependencies
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_DEFINES_SVH
// implication checked at every rising clock edge outside reset
`define QTE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define QTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> sv/qte_pkg.sv
// shared constants, types and functions of the quaternion to euler unit
// no dependencies
`default_nettype none
package qte_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN = 24;
	localparam int QW = 16;
	localparam int THR_W = 15;
	localparam int PITCH_W = 15;
	localparam int ANG_W = 16;
	// datapath width of cordic x and y (q.28 values with growth)
	localparam int XYW = 36;
	// angle accumulator width, degrees with 20 fraction bits
	localparam int ACCW = 30;
	localparam int SQW = 29;
	localparam logic signed [XYW-1:0] ONE_Q28 = XYW'(64'sd268435456);
	localparam logic signed [ACCW-1:0] DEG180 = ACCW'(64'sd188743680);

	typedef logic signed [ACCW-1:0] acc_t;
	typedef logic signed [XYW-1:0] xy_t;

	// input transaction: unit quaternion in q1.14
	typedef struct packed {
		logic signed [QW-1:0] qx;
		logic signed [QW-1:0] qy;
		logic signed [QW-1:0] qz;
		logic signed [QW-1:0] qw;
	} quat_t;

	// output transaction: angles in 1/128 degree and flags
	typedef struct packed {
		logic signed [PITCH_W-1:0] pitch_angle;
		logic signed [ANG_W-1:0] yaw_angle;
		logic signed [ANG_W-1:0] roll_angle;
		logic gimbal_locked;
		logic sine_clamped;
	} euler_t;

	function automatic acc_t atan_lut(input logic [4:0] i);
		acc_t r;
		case (i)
			5'd0: r = 30'sd47185920;
			5'd1: r = 30'sd27855475;
			5'd2: r = 30'sd14718068;
			5'd3: r = 30'sd7471121;
			5'd4: r = 30'sd3750058;
			5'd5: r = 30'sd1876857;
			5'd6: r = 30'sd938658;
			5'd7: r = 30'sd469357;
			5'd8: r = 30'sd234682;
			5'd9: r = 30'sd117342;
			5'd10: r = 30'sd58671;
			5'd11: r = 30'sd29335;
			5'd12: r = 30'sd14668;
			5'd13: r = 30'sd7334;
			5'd14: r = 30'sd3667;
			5'd15: r = 30'sd1833;
			5'd16: r = 30'sd917;
			5'd17: r = 30'sd458;
			5'd18: r = 30'sd229;
			5'd19: r = 30'sd115;
			5'd20: r = 30'sd57;
			5'd21: r = 30'sd29;
			5'd22: r = 30'sd14;
			5'd23: r = 30'sd7;
			default: r = '0;
		endcase
		return r;
	endfunction

	// round half up to 1/128 degree and saturate
	function automatic logic signed [ANG_W-1:0] to_units(input acc_t a,
			input logic signed [ANG_W-1:0] lim);
		logic signed [ACCW:0] t;
		logic signed [ACCW-13:0] u;
		t = {a[ACCW-1], a} + (ACCW+1)'(4096);
		u = t[ACCW:13];
		if (u > (ACCW-12)'(lim)) return lim;
		if (u < -(ACCW-12)'(lim)) return -lim;
		return ANG_W'(u);
	endfunction
endpackage
`default_nettype wire

>>> sv/qte_if.sv
// valid/ready channel with a generic payload
// depends on nothing
`default_nettype none
interface qte_if #(parameter type payload_t = logic) (input wire logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/qte_cordic.sv
// pipelined cordic vectoring atan2, one stage per rotation
// depends on qte_pkg
`default_nettype none
module qte_cordic #(
	parameter int STAGES = qte_pkg::CORDIC_STAGES,
	parameter int TW = 4
) (
	input wire logic clk,
	input wire logic en,
	input wire qte_pkg::xy_t y_in,
	input wire qte_pkg::xy_t x_in,
	input wire logic [TW-1:0] tag_in,
	output qte_pkg::acc_t ang_out,
	output logic [TW-1:0] tag_out
);
	localparam int N = (STAGES < qte_pkg::TABLE_LEN) ? STAGES : qte_pkg::TABLE_LEN;
	qte_pkg::xy_t x_s [0:N];
	qte_pkg::xy_t y_s [0:N];
	qte_pkg::acc_t a_s [0:N];
	logic zero_s [0:N];
	logic [TW-1:0] tag_s [0:N];

	// pre-rotation into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			tag_s[0] <= tag_in;
			if (x_in[qte_pkg::XYW-1]) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				a_s[0] <= y_in[qte_pkg::XYW-1] ? -qte_pkg::DEG180 : qte_pkg::DEG180;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				a_s[0] <= '0;
			end
		end
	end

	// rotation stages
	for (genvar i = 0; i < N; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				tag_s[i+1] <= tag_s[i];
				if (!y_s[i][qte_pkg::XYW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + qte_pkg::atan_lut(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - qte_pkg::atan_lut(5'(i));
				end
			end
		end
	end

	assign ang_out = zero_s[N] ? '0 : a_s[N];
	assign tag_out = tag_s[N];
endmodule
`default_nettype wire

>>> sv/qte_sqrt.sv
// pipelined restoring square root of 2^56 - s^2, two result bits per stage
// depends on qte_pkg
`default_nettype none
module qte_sqrt (
	input wire logic clk,
	input wire logic en,
	input wire logic [57:0] d_in,
	output logic [qte_pkg::SQW-1:0] root
);
	localparam int ST = 15;
	logic [57:0] rem_s [0:ST];
	logic [58:0] res_s [0:ST];
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= d_in;
			res_s[0] <= '0;
		end
	end
	for (genvar k = 0; k < ST; k++) begin : g_sq
		localparam int B1 = 58 - 4*k;
		logic [57:0] r1, r2;
		logic [58:0] q1, q2;
		always_comb begin
			r1 = rem_s[k];
			q1 = res_s[k];
			if (B1 - 0 >= 0) begin
				if ({1'b0, r1} >= q1 + (59'(1) << (B1 > 0 ? B1 : 0))) begin
					r1 = 58'({1'b0, r1} - q1 - (59'(1) << (B1 > 0 ? B1 : 0)));
					q1 = (q1 >> 1) + (59'(1) << (B1 > 0 ? B1 : 0));
				end else begin
					q1 = q1 >> 1;
				end
			end
			r2 = r1;
			q2 = q1;
			if (B1 - 2 >= 0) begin
				if ({1'b0, r2} >= q2 + (59'(1) << (B1 > 2 ? B1-2 : 0))) begin
					r2 = 58'({1'b0, r2} - q2 - (59'(1) << (B1 > 2 ? B1-2 : 0)));
					q2 = (q2 >> 1) + (59'(1) << (B1 > 2 ? B1-2 : 0));
				end else begin
					q2 = q2 >> 1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= r2;
				res_s[k+1] <= q2;
			end
		end
	end
	assign root = res_s[ST][qte_pkg::SQW-1:0];
endmodule
`default_nettype wire

>>> sv/quaternion_to_euler_angles_unit.sv
// quaternion to euler angles (y-x-z), fully pipelined
// yaw and roll are aligned to pitch at the output
// throughput: one transaction per cycle; the whole pipe advances unless the output stalls
// reset: arst_n clears valid bits and loads thr_q with 1
// depends on qte_pkg, qte_if, qte_cordic, qte_sqrt
`default_nettype none
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [qte_pkg::THR_W-1:0] cfg_wdata,
	qte_if.sink in_ch,
	qte_if.source out_ch
);
	localparam int N = (CORDIC_STAGES < qte_pkg::TABLE_LEN) ? CORDIC_STAGES : qte_pkg::TABLE_LEN;
	localparam int SQL = 15;
	localparam int CL = N + 1;
	localparam int PRE = 3;
	// products, sums, square, root (load plus SQL stages), decision, cordic, output
	localparam int TOT = PRE + SQL + 1 + 1 + CL + 1;

	logic [qte_pkg::THR_W-1:0] thr_q;
	logic en;
	logic [TOT-1:0] vld_q;

	// pipe advances when the output slot is free or taken
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= qte_pkg::THR_W'(1);
			vld_q <= '0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (en) vld_q <= {vld_q[TOT-2:0], in_ch.valid};
		end
	end

	// stage 1: products
	logic signed [31:0] wx_s1, yz_s1, xz_s1, yw_s1, ww_s1, zz_s1, xy_s1, zw_s1, yy_s1, xx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= in_ch.data.qw * in_ch.data.qx;
			yz_s1 <= in_ch.data.qy * in_ch.data.qz;
			xz_s1 <= in_ch.data.qx * in_ch.data.qz;
			yw_s1 <= in_ch.data.qy * in_ch.data.qw;
			ww_s1 <= in_ch.data.qw * in_ch.data.qw;
			zz_s1 <= in_ch.data.qz * in_ch.data.qz;
			xy_s1 <= in_ch.data.qx * in_ch.data.qy;
			zw_s1 <= in_ch.data.qz * in_ch.data.qw;
			yy_s1 <= in_ch.data.qy * in_ch.data.qy;
			xx_s1 <= in_ch.data.qx * in_ch.data.qx;
		end
	end

	// stage 2: sums, sine saturation
	qte_pkg::xy_t s_s2, ya_s2, xa_s2, rb_s2, xb_s2, yl_s2, xl_s2;
	logic clamp_s2;
	qte_pkg::xy_t sraw;
	always_comb sraw = 36'(2) * (36'(wx_s1) - 36'(yz_s1));
	always_ff @(posedge clk) begin
		if (en) begin
			if (sraw > qte_pkg::ONE_Q28) begin
				s_s2 <= qte_pkg::ONE_Q28; clamp_s2 <= 1'b1;
			end else if (sraw < -qte_pkg::ONE_Q28) begin
				s_s2 <= -qte_pkg::ONE_Q28; clamp_s2 <= 1'b1;
			end else begin
				s_s2 <= sraw; clamp_s2 <= 1'b0;
			end
			ya_s2 <= 36'(2) * (36'(xz_s1) + 36'(yw_s1));
			xa_s2 <= 36'(2) * (36'(ww_s1) + 36'(zz_s1)) - qte_pkg::ONE_Q28;
			rb_s2 <= 36'(2) * (36'(xy_s1) + 36'(zw_s1));
			xb_s2 <= 36'(2) * (36'(ww_s1) + 36'(yy_s1)) - qte_pkg::ONE_Q28;
			yl_s2 <= -36'(2) * (36'(xz_s1) - 36'(yw_s1));
			xl_s2 <= 36'(2) * (36'(ww_s1) + 36'(xx_s1)) - qte_pkg::ONE_Q28;
		end
	end

	// stage 3: 2^56 minus the square of the sine magnitude
	logic [28:0] mag;
	assign mag = s_s2[qte_pkg::XYW-1] ? 29'(-s_s2) : 29'(s_s2);
	logic [57:0] d_s3;
	always_ff @(posedge clk) begin
		if (en) d_s3 <= 58'(58'(1) << 56) - 58'(mag) * 58'(mag);
	end

	// delay line for sine, clamp flag and cordic arguments across the square root
	localparam int DL = SQL + 1;
	qte_pkg::xy_t s_d [0:DL];
	qte_pkg::xy_t ya_d [0:DL], xa_d [0:DL], rb_d [0:DL], xb_d [0:DL];
	qte_pkg::xy_t yl_d [0:DL], xl_d [0:DL];
	logic cl_d [0:DL];
	always_ff @(posedge clk) begin
		if (en) begin
			s_d[0] <= s_s2; ya_d[0] <= ya_s2; xa_d[0] <= xa_s2; rb_d[0] <= rb_s2;
			xb_d[0] <= xb_s2; yl_d[0] <= yl_s2; xl_d[0] <= xl_s2; cl_d[0] <= clamp_s2;
			for (int k = 0; k < DL; k++) begin
				s_d[k+1] <= s_d[k]; ya_d[k+1] <= ya_d[k]; xa_d[k+1] <= xa_d[k];
				rb_d[k+1] <= rb_d[k]; xb_d[k+1] <= xb_d[k]; yl_d[k+1] <= yl_d[k];
				xl_d[k+1] <= xl_d[k]; cl_d[k+1] <= cl_d[k];
			end
		end
	end

	logic [qte_pkg::SQW-1:0] c_root;
	qte_sqrt u_sqrt (.clk(clk), .en(en), .d_in(d_s3), .root(c_root));

	// stage after root: gimbal decision and argument selection
	qte_pkg::xy_t s_c, c_c, yy_c, yx_c, ry_c, rx_c;
	logic lk_c, cl_c;
	always_ff @(posedge clk) begin
		if (en) begin
			s_c <= s_d[DL];
			c_c <= 36'(c_root);
			lk_c <= !(36'(c_root) > 36'({thr_q, 14'b0}));
			cl_c <= cl_d[DL];
			if (36'(c_root) > 36'({thr_q, 14'b0})) begin
				yy_c <= ya_d[DL]; yx_c <= xa_d[DL];
			end else begin
				yy_c <= yl_d[DL]; yx_c <= xl_d[DL];
			end
			ry_c <= rb_d[DL]; rx_c <= xb_d[DL];
		end
	end

	qte_pkg::acc_t pa, ya, ra;
	logic [1:0] tg;
	logic [1:0] tg_u1, tg_u2;
	qte_cordic #(.STAGES(CORDIC_STAGES), .TW(2)) u_cp (.clk(clk), .en(en),
		.y_in(s_c), .x_in(c_c), .tag_in({lk_c, cl_c}), .ang_out(pa), .tag_out(tg));
	qte_cordic #(.STAGES(CORDIC_STAGES), .TW(2)) u_cy (.clk(clk), .en(en),
		.y_in(yy_c), .x_in(yx_c), .tag_in(2'b0), .ang_out(ya), .tag_out(tg_u1));
	qte_cordic #(.STAGES(CORDIC_STAGES), .TW(2)) u_cr (.clk(clk), .en(en),
		.y_in(ry_c), .x_in(rx_c), .tag_in(2'b0), .ang_out(ra), .tag_out(tg_u2));
	logic unused_tg;
	assign unused_tg = ^{tg_u1, tg_u2};

	// output register
	logic signed [qte_pkg::ANG_W-1:0] pu;
	assign pu = qte_pkg::to_units(pa, 16'sd11520);
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.pitch_angle <= qte_pkg::PITCH_W'(pu);
			out_ch.data.yaw_angle <= qte_pkg::to_units(ya, 16'sd23040);
			out_ch.data.roll_angle <= tg[1] ? '0 : qte_pkg::to_units(ra, 16'sd23040);
			out_ch.data.gimbal_locked <= tg[1];
			out_ch.data.sine_clamped <= tg[0];
		end
	end
	assign out_ch.valid = vld_q[TOT-1];
endmodule
`default_nettype wire

>>> sv/qte_checker.sv
// port-level checks on the quaternion to euler unit
// depends on the defines header and the top level ports
`default_nettype none
`include "quaternion_to_euler_angles_unit_defines.svh"
module qte_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic locked,
	input wire logic [15:0] roll
);
	`QTE_ASSERT_IMPL(a_roll_zero, clk, arst_n, out_valid && locked, roll == 16'd0, "roll not zero when locked")
	`QTE_ASSERT_IMPL(a_ready, clk, arst_n, !out_valid, in_ready, "input stalled with empty output")
	`QTE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped under stall")
endmodule
bind quaternion_to_euler_angles_unit qte_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .locked(out_ch.data.gimbal_locked),
	.roll(out_ch.data.roll_angle));
`default_nettype wire

>>> test/quaternion_to_euler_angles_unit_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the quaternion to euler angles unit (y-x-z order)
// depends on qte_pkg, qte_if and the unit itself
module quaternion_to_euler_angles_unit_test;
	// directed row: flags typed in where they are obvious
	typedef struct packed {
		qte_pkg::quat_t q;
		logic flags_known;
		logic locked_exp;
		logic clamped_exp;
	} dir_row_t;

	localparam int PIPE_LAT = 40;
	localparam int STALL_LIMIT = 5000;
	localparam int RAND_PER_PHASE = 210;
	localparam longint UNIT_Q28 = 64'sd268435456;
	localparam longint HALF_TURN = 64'sd188743680;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [qte_pkg::THR_W-1:0] cfg_wdata;

	qte_if #(.payload_t(qte_pkg::quat_t)) in_ch (clk);
	qte_if #(.payload_t(qte_pkg::euler_t)) out_ch (clk);

	quaternion_to_euler_angles_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	longint atan_step_deg[24] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	qte_pkg::euler_t pending_angles[$];
	logic [qte_pkg::THR_W-1:0] lock_bound;
	logic no_idle;
	int errors;
	int sent;
	int received;
	int locked_seen;
	int clamped_seen;
	int stall_cycles;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned d);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > d) b = b >> 2;
		while (b != 0) begin
			if (d >= res + b) begin
				d = d - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// vectoring rotations, angle in degrees with 20 fraction bits
	function automatic longint vector_angle(input longint y, input longint x);
		longint acc;
		longint xs;
		longint ys;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			acc = (y >= 0) ? HALF_TURN : -HALF_TURN;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < qte_pkg::CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				acc += atan_step_deg[i];
			end else begin
				x = x - ys;
				y = y + xs;
				acc -= atan_step_deg[i];
			end
		end
		return acc;
	endfunction

	// round half up to 1/128 degree, then saturate
	function automatic longint deg_to_units(input longint a, input longint lim);
		longint u;
		u = (a + 4096) >>> 13;
		if (u > lim) u = lim;
		if (u < -lim) u = -lim;
		return u;
	endfunction

	function automatic qte_pkg::euler_t euler_from_quat(input qte_pkg::quat_t q,
			input logic [qte_pkg::THR_W-1:0] thr);
		qte_pkg::euler_t r;
		longint x, y, z, w, s, c, yaw, roll;
		longint unsigned mag;
		logic clamped;
		logic locked;
		x = q.qx;
		y = q.qy;
		z = q.qz;
		w = q.qw;
		clamped = 1'b0;
		roll = 0;
		s = 2 * (w * x - y * z);
		if (s > UNIT_Q28) begin
			s = UNIT_Q28;
			clamped = 1'b1;
		end else if (s < -UNIT_Q28) begin
			s = -UNIT_Q28;
			clamped = 1'b1;
		end
		mag = (s < 0) ? -s : s;
		c = int_sqrt((64'd1 << 56) - mag * mag);
		r.pitch_angle = qte_pkg::PITCH_W'(deg_to_units(vector_angle(s, c), 11520));
		locked = !(c > (longint'(thr) << 14));
		if (!locked) begin
			yaw = vector_angle(2 * (x * z + y * w), 2 * (w * w + z * z) - UNIT_Q28);
			roll = deg_to_units(vector_angle(2 * (x * y + z * w),
				2 * (w * w + y * y) - UNIT_Q28), 23040);
		end else begin
			yaw = vector_angle(-2 * (x * z - y * w), 2 * (w * w + x * x) - UNIT_Q28);
		end
		r.yaw_angle = qte_pkg::ANG_W'(deg_to_units(yaw, 23040));
		r.roll_angle = qte_pkg::ANG_W'(roll);
		r.gimbal_locked = locked;
		r.sine_clamped = clamped;
		return r;
	endfunction

	// random quaternion: mostly unit length, some near the poles, some raw noise
	function automatic qte_pkg::quat_t random_quat();
		qte_pkg::quat_t q;
		real a[4];
		real n;
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			n = 0.0;
			for (int i = 0; i < 4; i++) begin
				a[i] = real'($urandom_range(0, 65535)) - 32767.5;
				n = n + a[i] * a[i];
			end
			n = $sqrt(n);
			q.qx = 16'($rtoi(a[0] * 16384.0 / n));
			q.qy = 16'($rtoi(a[1] * 16384.0 / n));
			q.qz = 16'($rtoi(a[2] * 16384.0 / n));
			q.qw = 16'($rtoi(a[3] * 16384.0 / n));
		end else if (kind < 8) begin
			// pitch near +-90: w = +-x, y = -+z
			a[0] = real'($urandom_range(1, 65535));
			a[1] = real'($urandom_range(0, 65535));
			n = $sqrt(2.0 * (a[0] * a[0] + a[1] * a[1]));
			q.qw = 16'($rtoi(a[0] * 16384.0 / n) * ($urandom_range(0, 1) ? 1 : -1));
			q.qx = 16'(($urandom_range(0, 1) ? q.qw : -q.qw)
				+ $signed($urandom_range(0, 6)) - 3);
			q.qy = 16'($rtoi(a[1] * 16384.0 / n) * ($urandom_range(0, 1) ? 1 : -1));
			q.qz = 16'((q.qx == q.qw ? -q.qy : q.qy) + $signed($urandom_range(0, 6)) - 3);
		end else begin
			q = qte_pkg::quat_t'({$urandom, $urandom});
		end
		return q;
	endfunction

	task automatic report_mismatch(input string field, input longint got, input longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", received, field, got, want);
		errors++;
	endtask

	// one input transaction, expectation queued on acceptance
	task automatic send_quat(input qte_pkg::quat_t q, input logic flags_known,
			input logic locked_exp, input logic clamped_exp);
		qte_pkg::euler_t e;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= q;
		do @(posedge clk); while (!in_ch.ready);
		e = euler_from_quat(q, lock_bound);
		if (flags_known) begin
			e.gimbal_locked = locked_exp;
			e.sine_clamped = clamped_exp;
		end
		pending_angles.push_back(e);
		sent++;
	endtask

	// write the threshold once the pipe has drained
	task automatic set_threshold(input logic [qte_pkg::THR_W-1:0] v);
		in_ch.valid <= 1'b0;
		wait (pending_angles.size() == 0);
		repeat (PIPE_LAT) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lock_bound = v;
	endtask

	// output side: random stall bursts
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!no_idle && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		qte_pkg::euler_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_angles.size() == 0) begin
				$display("unexpected result transaction %0d", received);
				errors++;
			end else begin
				e = pending_angles.pop_front();
				if (out_ch.data.pitch_angle !== e.pitch_angle)
					report_mismatch("pitch_angle", out_ch.data.pitch_angle, e.pitch_angle);
				if (out_ch.data.yaw_angle !== e.yaw_angle)
					report_mismatch("yaw_angle", out_ch.data.yaw_angle, e.yaw_angle);
				if (out_ch.data.roll_angle !== e.roll_angle)
					report_mismatch("roll_angle", out_ch.data.roll_angle, e.roll_angle);
				if (out_ch.data.gimbal_locked !== e.gimbal_locked)
					report_mismatch("gimbal_locked", out_ch.data.gimbal_locked, e.gimbal_locked);
				if (out_ch.data.sine_clamped !== e.sine_clamped)
					report_mismatch("sine_clamped", out_ch.data.sine_clamped, e.sine_clamped);
				if (e.gimbal_locked) locked_seen++;
				if (e.sine_clamped) clamped_seen++;
			end
			received++;
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d idle cycles", stall_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		dir_row_t dir_rows[$];
		logic [qte_pkg::THR_W-1:0] phase_bounds[6];
		errors = 0;
		sent = 0;
		received = 0;
		locked_seen = 0;
		clamped_seen = 0;
		stall_cycles = 0;
		no_idle = 1'b0;
		lock_bound = 1;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity, zero, axis extremes, saturated sine, negative atan2 x, pole
		dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, 1'b1, 1'b1});
		dir_rows.push_back('{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, 1'b1, 1'b1});
		dir_rows.push_back('{'{16'sh8000, 16'sd0, 16'sd0, 16'sh8000}, 1'b1, 1'b1, 1'b1});
		dir_rows.push_back('{'{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, -16'sd16384, 16'sd0, 16'sd0}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, 16'sd0, -16'sd16384, 16'sd0}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, -16'sd16384}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd11585, 16'sd0, 16'sd0, -16'sd11585}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, -16'sd11585, 16'sd0, 16'sd11585}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd0, 16'sd11585, 16'sd0, -16'sd11585}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}, 1'b0, 1'b0, 1'b0});
		dir_rows.push_back('{'{16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192}, 1'b0, 1'b0, 1'b0});

		// threshold settings, extremes included; from 16384 up everything locks
		phase_bounds = '{15'd1, 15'd0, 15'd16384, 15'd32767, 15'd11585, 15'd0};
		phase_bounds[5] = 15'($urandom_range(0, 16384));
		for (int p = 0; p < 6; p++) begin
			set_threshold(phase_bounds[p]);
			if (p == 0)
				foreach (dir_rows[i])
					send_quat(dir_rows[i].q, dir_rows[i].flags_known,
						dir_rows[i].locked_exp, dir_rows[i].clamped_exp);
			if (p == 5) no_idle = 1'b1;
			repeat (RAND_PER_PHASE) send_quat(random_quat(), 1'b0, 1'b0, 1'b0);
		end
		in_ch.valid <= 1'b0;

		wait (pending_angles.size() == 0);
		repeat (PIPE_LAT) @(posedge clk);
		if (pending_angles.size() != 0) begin
			$display("%0d results never arrived", pending_angles.size());
			errors++;
		end
		$display("sent %0d quaternions over 6 threshold settings, checked %0d results",
			sent, received);
		$display("%0d gimbal locked, %0d with saturated sine, %0d mismatches",
			locked_seen, clamped_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> sim.f
+incdir+sv
sv/qte_pkg.sv
sv/qte_if.sv
sv/qte_cordic.sv
sv/qte_sqrt.sv
sv/quaternion_to_euler_angles_unit.sv
sv/qte_checker.sv
test/quaternion_to_euler_angles_unit_test.sv
